### rtl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`endif

### rtl/pwve_pkg.sv
`default_nettype none
package pwve_pkg;
  localparam int VoiceCount = 8;
  localparam int KeyCount = 32;
  localparam int VW = $clog2(VoiceCount);
  localparam int KW = $clog2(KeyCount);
  localparam logic [7:0] NoVoice = 8'd255;

  typedef enum logic [2:0] {
    OP_SAMPLE = 3'd0,
    OP_ENV = 3'd1,
    OP_NOTE_ON = 3'd2,
    OP_NOTE_OFF = 3'd3,
    OP_WAVE = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_OFF = 3'd0,
    ST_ATTACK = 3'd1,
    ST_DECAY = 3'd2,
    ST_SUSTAIN = 3'd3,
    ST_RELEASE = 3'd4
  } stage_e;

  typedef enum logic [1:0] {
    REG_ATTACK = 2'd0,
    REG_DECAY = 2'd1,
    REG_SUSTAIN = 2'd2,
    REG_RELEASE = 2'd3
  } reg_e;
endpackage
`default_nettype wire

### rtl/pwve_mac.sv
`default_nettype none
// shared multiply unit: registered sample times amplitude, floor shift by 7
module pwve_mac (
  input  wire logic       clk_i,
  input  wire logic [7:0] tbl_i,
  input  wire logic [7:0] level_i,
  input  wire logic [7:0] trem_i,
  output logic      [7:0] prod_o
);
  logic signed [5:0] s;
  logic signed [12:0] amp;
  logic signed [19:0] p;
  logic [7:0] prod_q;
  assign s = 6'(signed'(tbl_i) >>> 2);
  assign amp = signed'({5'd0, level_i}) + signed'({{1{trem_i[7]}}, trem_i, 4'd0});
  assign p = 20'(s * amp);
  always_ff @(posedge clk_i) begin
    prod_q <= p[14:7];
  end
  assign prod_o = prod_q;
endmodule
`default_nettype wire

### rtl/polyphonic_wavetable_voice_engine_unit.sv
// flow, input beat to result beat: a sample tick passes S_RD, S_MUL and S_ACC for each
// voice, an envelope tick and a note on pass S_STEP for each voice, other ops S_STEP
// once; each then ends in S_DONE, which registers the result beat
// throughput: one item at a time, next input taken the cycle after the result beat
// reset: voices off, key map none, write position zero, shapes to defaults;
// wavetable not cleared
`default_nettype none
module polyphonic_wavetable_voice_engine_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  op_i,
  input  wire logic [4:0]  key_i,
  input  wire logic [15:0] pitch_step_i,
  input  wire logic signed [7:0] vibrato_amount_i,
  input  wire logic signed [7:0] tremolo_amount_i,
  input  wire logic signed [7:0] wave_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       dac_level_o,
  output logic [2:0]       chosen_voice_o,
  output logic             voice_found_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i
);
  import pwve_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_RD = 6'b000010, S_MUL = 6'b000100,
    S_ACC = 6'b001000, S_STEP = 6'b010000, S_DONE = 6'b100000
  } fsm_e;

  fsm_e st_q;
  logic [23:0] att_q, dec_q;
  logic [15:0] sus_q, rel_q;
  stage_e stage_q [VoiceCount];
  logic [7:0] lvl_q [VoiceCount];
  logic [7:0] cnt_q [VoiceCount];
  logic [15:0] ph_q [VoiceCount];
  logic [15:0] inc_q [VoiceCount];
  logic [KW-1:0] own_q [VoiceCount];
  logic [7:0] map_q [KeyCount];
  logic [7:0] wt_q [256];
  logic [7:0] wpos_q, rd_q, sum_q, bestlvl_q;
  logic [VW:0] vi_q;
  logic [VW-1:0] v;
  logic [VW-1:0] best_q;
  logic bestok_q, bestoff_q;
  op_e op_q;
  logic [4:0] key_q;
  logic [15:0] pitch_q;
  logic [7:0] vib_q, trem_q;
  logic [7:0] prod;
  logic ov_q;
  logic [7:0] dac_q;
  logic [2:0] ch_q;
  logic fd_q;

  assign v = vi_q[VW-1:0];
  assign in_stall_o = (st_q != S_IDLE) || ov_q;

  pwve_mac u_mac (.clk_i(clk_i), .tbl_i(rd_q), .level_i(lvl_q[v]), .trem_i(trem_q),
    .prod_o(prod));

  always_ff @(posedge clk_i) begin
    rd_q <= wt_q[ph_q[v][15:8]];
    if (st_q == S_IDLE && in_valid_i && !ov_q && op_i == OP_WAVE) wt_q[wpos_q] <= wave_byte_i;
  end

  // envelope step for voice v
  logic [23:0] shp;
  logic [7:0] tg, sp, dl, cn1, lnew;
  logic signed [8:0] rest;
  always_comb begin
    case (stage_q[v])
      ST_ATTACK: shp = att_q;
      ST_DECAY: shp = dec_q;
      ST_SUSTAIN: shp = {8'd0, sus_q};
      default: shp = {8'd0, rel_q};
    endcase
    tg = shp[23:16]; sp = shp[15:8]; dl = shp[7:0];
    cn1 = cnt_q[v] + 8'd1;
    lnew = (stage_q[v] == ST_ATTACK) ? lvl_q[v] + sp : lvl_q[v] - sp;
    rest = signed'({1'b0, lvl_q[v]}) - signed'({1'b0, sp});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ov_q <= 1'b0; wpos_q <= '0; vi_q <= '0;
      att_q <= 24'h808000; dec_q <= 24'h800100; sus_q <= 16'h00ff; rel_q <= 16'h8000;
      for (int i = 0; i < VoiceCount; i++) begin
        stage_q[i] <= ST_OFF; lvl_q[i] <= '0; cnt_q[i] <= '0; ph_q[i] <= '0;
      end
      for (int k = 0; k < KeyCount; k++) map_q[k] <= NoVoice;
    end else begin
      if (cfg_we_i) begin
        case (reg_e'(cfg_index_i))
          REG_ATTACK: att_q <= cfg_data_i;
          REG_DECAY: dec_q <= cfg_data_i;
          REG_SUSTAIN: sus_q <= cfg_data_i[15:0];
          REG_RELEASE: rel_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      case (st_q)
        S_IDLE: begin
          if (in_valid_i && !ov_q) begin
            op_q <= op_e'(op_i); key_q <= key_i; pitch_q <= pitch_step_i;
            vib_q <= vibrato_amount_i; trem_q <= tremolo_amount_i;
            vi_q <= '0; sum_q <= '0; bestok_q <= 1'b0; bestoff_q <= 1'b0;
            if (op_i == OP_WAVE) wpos_q <= wpos_q + 8'd1;
            st_q <= (op_i == OP_SAMPLE) ? S_RD : S_STEP;
          end
        end
        S_RD: st_q <= S_MUL;
        S_MUL: st_q <= S_ACC;
        S_ACC: begin
          if (stage_q[v] != ST_OFF) begin
            sum_q <= sum_q + prod;
            ph_q[v] <= ph_q[v] + inc_q[v] + {{4{vib_q[7]}}, vib_q, 4'd0};
          end
          vi_q <= vi_q + 1'b1;
          st_q <= (vi_q == (VW+1)'(VoiceCount - 1)) ? S_DONE : S_RD;
        end
        S_STEP: begin
          vi_q <= vi_q + 1'b1;
          if (op_q == OP_ENV) begin
            if (stage_q[v] != ST_OFF) begin
              if (cn1 < dl) cnt_q[v] <= cn1;
              else begin
                cnt_q[v] <= '0;
                case (stage_q[v])
                  ST_ATTACK: begin
                    lvl_q[v] <= lnew;
                    if (lnew >= tg) stage_q[v] <= ST_DECAY;
                  end
                  ST_DECAY: begin
                    lvl_q[v] <= lnew;
                    if (lnew <= tg) stage_q[v] <= ST_SUSTAIN;
                  end
                  default: begin
                    if (rest <= 0) begin
                      if (stage_q[v] == ST_SUSTAIN) map_q[own_q[v]] <= NoVoice;
                      stage_q[v] <= ST_OFF;
                    end else lvl_q[v] <= rest[7:0];
                  end
                endcase
              end
            end
          end else if (op_q == OP_NOTE_ON) begin
            // search: first off voice wins, else lowest releasing level
            if (!bestoff_q) begin
              if (stage_q[v] == ST_OFF) begin
                best_q <= v; bestok_q <= 1'b1; bestoff_q <= 1'b1;
              end else if (stage_q[v] == ST_RELEASE && (!bestok_q || lvl_q[v] < bestlvl_q)) begin
                best_q <= v; bestok_q <= 1'b1; bestlvl_q <= lvl_q[v];
              end
            end
          end else if (op_q == OP_NOTE_OFF) begin
            if (map_q[key_q] < 8'(VoiceCount)) begin
              if (stage_q[map_q[key_q][VW-1:0]] != ST_OFF) begin
                stage_q[map_q[key_q][VW-1:0]] <= ST_RELEASE;
                cnt_q[map_q[key_q][VW-1:0]] <= '0;
              end
            end
            map_q[key_q] <= NoVoice;
          end
          if (op_q != OP_ENV && op_q != OP_NOTE_ON) st_q <= S_DONE;
          else if (vi_q == (VW+1)'(VoiceCount - 1)) st_q <= S_DONE;
        end
        S_DONE: begin
          dac_q <= (op_q == OP_SAMPLE) ? 8'd127 + sum_q : 8'd0;
          ch_q <= (op_q == OP_NOTE_ON && bestok_q) ? 3'(best_q) : 3'd0;
          fd_q <= (op_q == OP_NOTE_ON && bestok_q);
          if (op_q == OP_NOTE_ON && bestok_q) begin
            inc_q[best_q] <= pitch_q; own_q[best_q] <= key_q;
            lvl_q[best_q] <= '0; cnt_q[best_q] <= '0; stage_q[best_q] <= ST_ATTACK;
            map_q[key_q] <= 8'(best_q);
          end
          ov_q <= 1'b1;
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = ov_q;
  assign dac_level_o = dac_q;
  assign chosen_voice_o = ch_q;
  assign voice_found_o = fd_q;
endmodule
`default_nettype wire

### rtl/pwve_checker.sv
`default_nettype none
`include "assert_macros.svh"
module pwve_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic [7:0] dac_level_o,
  input wire logic [2:0] chosen_voice_o,
  input wire logic voice_found_o
);
  `ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "no stall after take")
  `ASSERT_IMPL(a_stall_while_out, clk_i, rst_ni, !out_valid_o || in_stall_o, "accepted with result pending")
  `ASSERT_IMPL(a_found_chosen, clk_i, rst_ni, !out_valid_o || voice_found_o || chosen_voice_o == 3'd0, "chosen without found")
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(dac_level_o), "result dropped")
endmodule
bind polyphonic_wavetable_voice_engine_unit pwve_checker u_chk (.*);
`default_nettype wire

### tb/polyphonic_wavetable_voice_engine_unit_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module polyphonic_wavetable_voice_engine_unit_tb;
  import pwve_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_MID = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int SETTLE_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int PHASE_COUNT = 6;

  typedef struct packed {
    logic [2:0]  op;
    logic [4:0]  key;
    logic [15:0] pitch;
    logic signed [7:0] vib;
    logic signed [7:0] trem;
    logic signed [7:0] wbyte;
  } beat_t;

  typedef struct packed {
    logic [7:0] dac;
    logic [2:0] chosen;
    logic       found;
  } mix_t;

  typedef struct packed {
    beat_t beat;
    logic  typed;
    mix_t  res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] op_i = '0;
  logic [4:0] key_i = '0;
  logic [15:0] pitch_step_i = '0;
  logic signed [7:0] vibrato_amount_i = '0;
  logic signed [7:0] tremolo_amount_i = '0;
  logic signed [7:0] wave_byte_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] dac_level_o;
  logic [2:0] chosen_voice_o;
  logic voice_found_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;

  polyphonic_wavetable_voice_engine_unit u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .op_i, .key_i, .pitch_step_i,
    .vibrato_amount_i, .tremolo_amount_i, .wave_byte_i, .out_valid_o, .out_stall_i,
    .dac_level_o, .chosen_voice_o, .voice_found_o, .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // model of the engine
  logic [23:0] shape_q [4];
  stage_e      v_stage [VoiceCount];
  logic [7:0]  v_level [VoiceCount];
  logic [7:0]  v_cnt [VoiceCount];
  logic [15:0] v_phase [VoiceCount];
  logic [15:0] v_inc [VoiceCount];
  logic [4:0]  v_owner [VoiceCount];
  logic [7:0]  key_map [KeyCount];
  logic [7:0]  wave_mem [256];
  logic [7:0]  wr_pos;

  mix_t pending_mix [$];
  int   errors = 0;
  int   snd_pct = 0;
  int   rcv_pct = 0;
  int   quiet_cycles = 0;

  task automatic step_envelope(input int i);
    logic [23:0] sh;
    int rest;
    begin
      case (v_stage[i])
        ST_ATTACK: sh = shape_q[REG_ATTACK];
        ST_DECAY: sh = shape_q[REG_DECAY];
        ST_SUSTAIN: sh = shape_q[REG_SUSTAIN];
        default: sh = shape_q[REG_RELEASE];
      endcase
      v_cnt[i] = v_cnt[i] + 8'd1;
      if (v_cnt[i] >= sh[7:0]) begin
        v_cnt[i] = '0;
        if (v_stage[i] == ST_ATTACK) begin
          v_level[i] = v_level[i] + sh[15:8];
          if (v_level[i] >= sh[23:16]) v_stage[i] = ST_DECAY;
        end else if (v_stage[i] == ST_DECAY) begin
          v_level[i] = v_level[i] - sh[15:8];
          if (v_level[i] <= sh[23:16]) v_stage[i] = ST_SUSTAIN;
        end else begin
          rest = int'(v_level[i]) - int'(sh[15:8]);
          if (rest <= 0) begin
            if (v_stage[i] == ST_SUSTAIN) key_map[v_owner[i]] = NoVoice;
            v_stage[i] = ST_OFF;
          end else begin
            v_level[i] = rest[7:0];
          end
        end
      end
    end
  endtask

  task automatic compute_mix(input beat_t b, output mix_t r);
    int s, v, amp, best;
    logic [7:0] sum, vi;
    begin
      r = '0;
      case (b.op)
        OP_SAMPLE: begin
          sum = '0;
          for (int i = 0; i < VoiceCount; i++) begin
            if (v_stage[i] != ST_OFF) begin
              s = int'($signed(wave_mem[v_phase[i][15:8]])) >>> 2;
              amp = int'(v_level[i]) + int'(b.trem) * 16;
              v = (s * amp) >>> 7;
              sum = sum + v[7:0];
              v_phase[i] = v_phase[i] + v_inc[i] + 16'(int'(b.vib) * 16);
            end
          end
          r.dac = 8'd127 + sum;
        end
        OP_ENV: begin
          for (int i = 0; i < VoiceCount; i++)
            if (v_stage[i] != ST_OFF) step_envelope(i);
        end
        OP_NOTE_ON: begin
          best = -1;
          for (int i = 0; i < VoiceCount; i++) begin
            if (v_stage[i] == ST_OFF) begin
              best = i;
              break;
            end
            if (v_stage[i] == ST_RELEASE && (best < 0 || v_level[i] < v_level[best]))
              best = i;
          end
          if (best >= 0) begin
            v_inc[best] = b.pitch;
            v_owner[best] = b.key;
            v_level[best] = '0;
            v_cnt[best] = '0;
            v_stage[best] = ST_ATTACK;
            key_map[b.key] = 8'(best);
            r.chosen = 3'(best);
            r.found = 1'b1;
          end
        end
        OP_NOTE_OFF: begin
          vi = key_map[b.key];
          if (vi < VoiceCount && v_stage[vi] != ST_OFF) begin
            v_stage[vi] = ST_RELEASE;
            v_cnt[vi] = '0;
          end
          key_map[b.key] = NoVoice;
        end
        OP_WAVE: begin
          wave_mem[wr_pos] = b.wbyte;
          wr_pos = wr_pos + 8'd1;
        end
        default: ;
      endcase
    end
  endtask

  // one beat in; typed rows push their own expectation
  task automatic send_beat(input beat_t b, input logic typed, input mix_t typed_res);
    mix_t r;
    begin
      while ($urandom_range(0, 99) < snd_pct) begin
        in_valid_i = 1'b0;
        @(negedge clk_i);
      end
      in_valid_i = 1'b1;
      op_i = b.op;
      key_i = b.key;
      pitch_step_i = b.pitch;
      vibrato_amount_i = b.vib;
      tremolo_amount_i = b.trem;
      wave_byte_i = b.wbyte;
      do @(posedge clk_i); while (in_stall_o);
      compute_mix(b, r);
      pending_mix.push_back(typed ? typed_res : r);
      @(negedge clk_i);
    end
  endtask

  task automatic drain();
    begin
      in_valid_i = 1'b0;
      while (pending_mix.size() != 0) @(negedge clk_i);
      repeat (SETTLE_CYCLES) @(negedge clk_i);
    end
  endtask

  task automatic write_shapes(input logic [23:0] a, input logic [23:0] d,
                              input logic [23:0] s, input logic [23:0] r);
    logic [23:0] vals [4];
    begin
      vals = '{a, d, s, r};
      for (int i = 0; i < 4; i++) begin
        cfg_we_i = 1'b1;
        cfg_index_i = 2'(i);
        cfg_data_i = vals[i];
        shape_q[i] = (i >= REG_SUSTAIN) ? {8'd0, vals[i][15:0]} : vals[i];
        @(negedge clk_i);
      end
      cfg_we_i = 1'b0;
    end
  endtask

  function automatic beat_t random_beat();
    beat_t b;
    int pick;
    begin
      b = '0;
      b.pitch = 16'($urandom());
      b.vib = 8'($urandom());
      b.trem = 8'($urandom());
      b.wbyte = 8'($urandom());
      // a small key pool makes note off hit mapped voices
      b.key = ($urandom_range(0, 3) == 0) ? 5'($urandom()) : 5'($urandom_range(0, 9));
      pick = $urandom_range(0, 99);
      if (pick < 35) b.op = OP_SAMPLE;
      else if (pick < 62) b.op = OP_ENV;
      else if (pick < 78) b.op = OP_NOTE_ON;
      else if (pick < 92) b.op = OP_NOTE_OFF;
      else if (pick < 97) b.op = OP_WAVE;
      else b.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      return b;
    end
  endfunction

  always @(negedge clk_i) out_stall_i = ($urandom_range(0, 99) < rcv_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_mix.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        mix_t e;
        e = pending_mix.pop_front();
        if (dac_level_o !== e.dac) begin
          $error("dac_level expected %0d got %0d", e.dac, dac_level_o);
          errors++;
        end
        if (chosen_voice_o !== e.chosen) begin
          $error("chosen_voice expected %0d got %0d", e.chosen, chosen_voice_o);
          errors++;
        end
        if (voice_found_o !== e.found) begin
          $error("voice_found expected %0d got %0d", e.found, voice_found_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("polyphonic_wavetable_voice_engine_unit_tb failed");
      $finish;
    end
  end

  row_t directed [$];

  function automatic row_t mk(input logic [2:0] op, input logic [4:0] key,
                              input logic [15:0] pitch, input logic signed [7:0] vib,
                              input logic signed [7:0] trem, input logic typed,
                              input logic [7:0] dac, input logic [2:0] ch, input logic fd);
    row_t r;
    begin
      r = '0;
      r.beat.op = op;
      r.beat.key = key;
      r.beat.pitch = pitch;
      r.beat.vib = vib;
      r.beat.trem = trem;
      r.typed = typed;
      r.res.dac = dac;
      r.res.chosen = ch;
      r.res.found = fd;
      return r;
    end
  endfunction

  initial begin
    beat_t b;
    shape_q = '{24'h808000, 24'h800100, 24'h0000FF, 24'h008000};
    for (int i = 0; i < VoiceCount; i++) begin
      v_stage[i] = ST_OFF;
      v_level[i] = '0;
      v_cnt[i] = '0;
      v_phase[i] = '0;
      v_inc[i] = '0;
      v_owner[i] = '0;
    end
    for (int i = 0; i < KeyCount; i++) key_map[i] = NoVoice;
    for (int i = 0; i < 256; i++) wave_mem[i] = '0;
    wr_pos = '0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // the table must be fully written before any voice reads it
    for (int i = 0; i < 256; i++) begin
      b = '0;
      b.op = OP_WAVE;
      b.wbyte = (i == 0) ? 8'sd127 : (i == 1) ? -8'sd128 : 8'($urandom());
      send_beat(b, 1'b1, '0);
    end

    directed.push_back(mk(OP_SAMPLE, 0, 0, 127, -128, 1, 8'd127, 0, 0));
    directed.push_back(mk(OP_SPARE_LO, 31, 16'hFFFF, -1, -1, 1, 0, 0, 0));
    directed.push_back(mk(OP_SPARE_MID, 0, 0, 0, 0, 1, 0, 0, 0));
    directed.push_back(mk(OP_SPARE_HI, 0, 0, 0, 0, 1, 0, 0, 0));
    directed.push_back(mk(OP_NOTE_OFF, 31, 0, 0, 0, 1, 0, 0, 0));
    directed.push_back(mk(OP_NOTE_ON, 0, 16'h0000, 0, 0, 1, 0, 0, 1));
    directed.push_back(mk(OP_NOTE_ON, 31, 16'hFFFF, 0, 0, 1, 0, 1, 1));
    // same key again takes a new voice, the old one plays on
    directed.push_back(mk(OP_NOTE_ON, 0, 16'h1234, 0, 0, 1, 0, 2, 1));
    for (int k = 3; k < 8; k++) directed.push_back(mk(OP_NOTE_ON, 5'(k), 16'(k * 300),
                                                      0, 0, 1, 0, 3'(k), 1));
    // all voices busy and none releasing
    directed.push_back(mk(OP_NOTE_ON, 9, 16'h4000, 0, 0, 1, 0, 0, 0));
    directed.push_back(mk(OP_SAMPLE, 0, 0, 127, 127, 0, 0, 0, 0));
    directed.push_back(mk(OP_SAMPLE, 0, 0, -128, -128, 0, 0, 0, 0));
    directed.push_back(mk(OP_ENV, 0, 0, 0, 0, 1, 0, 0, 0));
    directed.push_back(mk(OP_NOTE_OFF, 31, 0, 0, 0, 1, 0, 0, 0));
    directed.push_back(mk(OP_NOTE_OFF, 0, 0, 0, 0, 1, 0, 0, 0));
    directed.push_back(mk(OP_ENV, 0, 0, 0, 0, 1, 0, 0, 0));
    // takes the first voice that the release step turned off
    directed.push_back(mk(OP_NOTE_ON, 12, 16'h0100, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(OP_SAMPLE, 0, 0, 1, 0, 0, 0, 0, 0));
    foreach (directed[i]) send_beat(directed[i].beat, directed[i].typed, directed[i].res);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain();
      case (p)
        1: write_shapes(24'h000000, 24'h000000, 24'h000000, 24'h000000);
        2: write_shapes(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        3, 4, 5: write_shapes({8'($urandom()), 8'($urandom_range(1, 64)),
                               8'($urandom_range(0, 3))},
                              {8'($urandom()), 8'($urandom_range(1, 64)),
                               8'($urandom_range(0, 3))},
                              {8'($urandom()), 8'($urandom_range(1, 64)),
                               8'($urandom_range(0, 3))},
                              {8'($urandom()), 8'($urandom_range(1, 64)),
                               8'($urandom_range(0, 3))});
        default: ;
      endcase
      case (p % 4)
        0: begin snd_pct = 0; rcv_pct = 0; end
        1: begin snd_pct = 86; rcv_pct = 0; end
        2: begin snd_pct = 0; rcv_pct = 86; end
        default: begin snd_pct = 8; rcv_pct = 8; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_beat(random_beat(), 1'b0, '0);
    end

    drain();
    if (errors == 0) $display("polyphonic_wavetable_voice_engine_unit_tb passed");
    else $display("polyphonic_wavetable_voice_engine_unit_tb failed");
    $finish;
  end
endmodule
`default_nettype wire
